FILE: hw/rtl/ppg_pkg.sv
`timescale 1ns / 1ps

package ppg_pkg;

    // Field and time widths.
    localparam int TIME_BITS  = 48;
    localparam int GRAN_BITS  = 20;
    localparam int BYTES_BITS = 16;
    localparam int BW_BITS    = 40;
    localparam int WAIT_BITS  = 48;
    localparam int CMD_BITS   = 2;

    // Transfer time at twice the estimate: bytes * 8 * 1e6 / (2 * bw).
    localparam int NUM_BITS = 22;
    localparam logic [NUM_BITS-1:0] PACING_NUMERATOR = 22'd4000000;

    // The product of bytes and the numerator fits in this many bits.
    localparam int PROD_BITS    = BYTES_BITS + NUM_BITS;
    localparam int DIV_STEPS    = PROD_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Register port.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_ALARM_GRANULARITY = 1'b0;
    localparam logic [GRAN_BITS-1:0] GRAN_RESET = 20'd1000;

    // Command codes.
    localparam logic [CMD_BITS-1:0] CMD_SEND_QUERY  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_PACKET_SENT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_RTT_SAMPLE  = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic [TIME_BITS-1:0]  now_us;
        logic [BYTES_BITS-1:0] packet_bytes;
        logic                  has_data;
        logic                  underlying_blocked;
        logic [BW_BITS-1:0]    bandwidth_bps;
    } t_ppg_in;

    typedef struct packed {
        logic [WAIT_BITS-1:0] wait_us;
        logic                 blocked;
    } t_ppg_out;

endpackage

FILE: hw/rtl/ppg_divider.sv
`timescale 1ns / 1ps

// Restoring divider that retires one quotient bit per cycle. The dividend
// shifts out of the top of the quotient register while quotient bits shift
// in at the bottom.
module ppg_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [ppg_pkg::PROD_BITS-1:0]      i_dividend,
    input  logic [ppg_pkg::BW_BITS-1:0]        i_divisor,
    output logic                               o_done,
    output logic [ppg_pkg::PROD_BITS-1:0]      o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [ppg_pkg::DIV_CNT_BITS-1:0]  r_cnt;
    logic [ppg_pkg::BW_BITS-1:0]       r_rem;
    logic [ppg_pkg::BW_BITS-1:0]       r_divisor;
    logic [ppg_pkg::PROD_BITS-1:0]     r_quo;

    logic [ppg_pkg::BW_BITS:0]         w_trial;
    logic [ppg_pkg::BW_BITS:0]         w_diff;
    logic                              w_ge;

    // One trial subtraction per cycle.
    assign w_trial = {r_rem, r_quo[ppg_pkg::PROD_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});
    assign w_diff  = w_trial - {1'b0, r_divisor};

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ppg_pkg::DIV_CNT_BITS'(ppg_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ppg_pkg::BW_BITS-1:0] : w_trial[ppg_pkg::BW_BITS-1:0];
            r_quo <= {r_quo[ppg_pkg::PROD_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/packet_pacing_gate.sv
`timescale 1ns / 1ps

// Packet pacer on top of an external congestion controller. Each input
// transfer carries one command and yields exactly one result transfer. A
// paced send query goes from the decode state through the states Q1, Q2 and
// Q3 to the done state. A blocked, ACK-only or early query, an RTT sample, an
// unused command and a sent packet that does not move the send time go from
// the decode state straight to the done state. A sent data packet with a
// nonzero bandwidth after an RTT sample waits in the divide state for the
// bit-serial divider, which works out the transfer time one quotient bit per
// cycle over 38 steps. One command is in work at a time; the finished result
// waits in an output register, so the next command can be accepted while the
// previous result is stalled, and a command whose result is ready waits in its
// last state until that register frees.
// The alarm granularity register lies at byte address 0 and resets to
// 1000 microseconds.
module packet_pacing_gate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ppg_pkg::t_ppg_in                   i_in_data,
    // Output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ppg_pkg::t_ppg_out                  o_out_data,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppg_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [ppg_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [ppg_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_Q1     = 3'd2;
    localparam logic [2:0] S_Q2     = 3'd3;
    localparam logic [2:0] S_Q3     = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam int TB = ppg_pkg::TIME_BITS;

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
        logic [TB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TB] ? {TB{1'b1}} : s[TB-1:0];
    endfunction

    function automatic logic [TB-1:0] sat_sub(input logic [TB-1:0] a, input logic [TB-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    logic [2:0]                         r_state, n_state;
    ppg_pkg::t_ppg_in                   r_in;
    ppg_pkg::t_ppg_out                  r_res, n_res;
    ppg_pkg::t_ppg_out                  r_out;
    logic                               r_out_valid;
    logic [ppg_pkg::GRAN_BITS-1:0]      r_gran;
    logic [TB-1:0]                      r_nst, n_nst;
    logic                               r_lsd, n_lsd;
    logic                               r_rtt, n_rtt;
    logic [TB-1:0]                      r_lim_nst;
    logic [TB-1:0]                      r_lim_now;

    logic                               w_div_start;
    logic                               w_div_done;
    logic [ppg_pkg::PROD_BITS-1:0]      w_prod;
    logic [ppg_pkg::PROD_BITS-1:0]      w_quo;
    logic [TB-1:0]                      w_gran;
    logic                               w_in_xfer;
    logic                               w_out_free;
    logic                               w_cfg_wr;

    assign w_gran     = TB'(r_gran);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_prod     = ppg_pkg::PROD_BITS'(ppg_pkg::PROD_BITS'(r_in.packet_bytes)
                        * ppg_pkg::PROD_BITS'(ppg_pkg::PACING_NUMERATOR));

    ppg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_in.bandwidth_bps),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Register port: only the granularity register exists.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[ppg_pkg::APB_ADDR_BITS-1:2] == ppg_pkg::REG_ALARM_GRANULARITY);
    assign prdata   = (paddr[ppg_pkg::APB_ADDR_BITS-1:2] == ppg_pkg::REG_ALARM_GRANULARITY)
                      ? ppg_pkg::APB_DATA_BITS'(r_gran) : '0;

    // Command sequencer.
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_nst       = r_nst;
        n_lsd       = r_lsd;
        n_rtt       = r_rtt;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res   = '0;
                n_state = S_DONE;
                case (r_in.command)
                    ppg_pkg::CMD_SEND_QUERY: begin
                        if (r_in.underlying_blocked) begin
                            n_res.wait_us = '1;
                            n_res.blocked = 1'b1;
                        end else if (r_rtt && r_in.has_data) begin
                            n_state = S_Q1;
                        end
                    end
                    ppg_pkg::CMD_PACKET_SENT: begin
                        if (r_in.has_data && r_rtt && (r_in.bandwidth_bps != '0)) begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                    ppg_pkg::CMD_RTT_SAMPLE: begin
                        n_rtt = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_Q1: begin
                n_state = S_Q2;
            end
            S_Q2: begin
                // Lost time is not made up once the sender has fallen behind.
                if (!r_lsd && ((r_nst == '0) || (r_in.now_us > r_lim_nst))) begin
                    n_nst = sat_sub(r_in.now_us, w_gran);
                end
                n_state = S_Q3;
            end
            S_Q3: begin
                if (r_nst > r_lim_now) begin
                    n_lsd         = 1'b1;
                    n_res.wait_us = ppg_pkg::WAIT_BITS'(r_nst - r_in.now_us);
                end else begin
                    n_lsd = 1'b0;
                end
                n_state = S_DONE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_nst   = sat_add(r_nst, TB'(w_quo));
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and pacing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gran      <= ppg_pkg::GRAN_RESET;
            r_nst       <= '0;
            r_lsd       <= 1'b0;
            r_rtt       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nst   <= n_nst;
            r_lsd   <= n_lsd;
            r_rtt   <= n_rtt;
            if (w_cfg_wr) begin
                r_gran <= pwdata[ppg_pkg::GRAN_BITS-1:0];
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
        if (r_state == S_Q1) begin
            r_lim_nst <= sat_add(r_nst, w_gran);
            r_lim_now <= sat_add(r_in.now_us, w_gran);
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // A result appears only after the sequencer finished a command.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result transfer without a finished command");

    // A delayed send always leaves an initialized next send time.
    a_delay_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lsd |-> (r_nst != '0))
        else $error("delayed send with uninitialized next send time");

    // A blocked answer carries an infinite wait.
    a_blocked_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.blocked) |-> (&o_out_data.wait_us))
        else $error("blocked result without infinite wait");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [ppg_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam logic [ppg_pkg::APB_ADDR_BITS-1:0] GRAN_ADDR =
        {ppg_pkg::REG_ALARM_GRANULARITY, 2'b00};
    localparam logic [63:0] TIME_MAX = (64'd1 << ppg_pkg::TIME_BITS) - 64'd1;
    localparam logic [63:0] WAIT_MAX = (64'd1 << ppg_pkg::WAIT_BITS) - 64'd1;
    localparam logic [ppg_pkg::TIME_BITS-1:0] NOW_MAX = '1;
    localparam logic [ppg_pkg::BW_BITS-1:0] BW_MAX = '1;
    localparam logic [ppg_pkg::BYTES_BITS-1:0] BYTES_MAX = '1;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum {STALL_NONE, STALL_HALF, STALL_MOST, STALL_TOGGLE} t_stall_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    ppg_pkg::t_ppg_in  i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    ppg_pkg::t_ppg_out o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ppg_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [ppg_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [ppg_pkg::APB_DATA_BITS-1:0] prdata;
    logic              pready;

    // Pacing state as the testbench predicts it.
    logic [63:0]                   pace_next = '0;
    logic                          pace_late = 1'b0;
    logic                          pace_rtt_seen = 1'b0;
    logic [ppg_pkg::GRAN_BITS-1:0] pace_gran = ppg_pkg::GRAN_RESET;

    // Expected results in order of acceptance, and the failure count.
    ppg_pkg::t_ppg_out wait_expect_q[$];
    int                errors = 0;

    // Sender burst state and the traffic clock of the random phases.
    int                            burst_left = 0;
    bit                            sender_steady = 1'b0;
    logic [ppg_pkg::TIME_BITS-1:0] traffic_now = '0;

    // Receiver stall pattern state; hold requests come from the tests.
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          idle_cycles = 0;

    packet_pacing_gate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] time_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a || s > TIME_MAX) ? TIME_MAX : s;
    endfunction

    function automatic logic [63:0] time_diff(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    // Advances the pacing state by one command and returns the expected answer.
    function automatic ppg_pkg::t_ppg_out pace_step(input ppg_pkg::t_ppg_in cmd_in);
        ppg_pkg::t_ppg_out res;
        logic [63:0]       now;
        logic [63:0]       gran;
        logic [63:0]       wait_v;
        logic [63:0]       bytes;
        logic [63:0]       bw;
        res.wait_us = '0;
        res.blocked = 1'b0;
        now = cmd_in.now_us;
        gran = pace_gran;
        bytes = cmd_in.packet_bytes;
        bw = cmd_in.bandwidth_bps;
        case (cmd_in.command)
            ppg_pkg::CMD_SEND_QUERY: begin
                if (cmd_in.underlying_blocked) begin
                    res.wait_us = '1;
                    res.blocked = 1'b1;
                end else if (pace_rtt_seen && cmd_in.has_data) begin
                    // Lost time is not made up once the sender falls behind.
                    if (!pace_late && (pace_next == 64'd0 ||
                                       now > time_sum(pace_next, gran))) begin
                        pace_next = time_diff(now, gran);
                    end
                    if (pace_next > time_sum(now, gran)) begin
                        pace_late = 1'b1;
                        wait_v = time_diff(pace_next, now);
                        res.wait_us = (wait_v > WAIT_MAX) ? '1
                                      : wait_v[ppg_pkg::WAIT_BITS-1:0];
                    end else begin
                        pace_late = 1'b0;
                    end
                end
            end
            ppg_pkg::CMD_PACKET_SENT: begin
                if (cmd_in.has_data && pace_rtt_seen && bw != 64'd0) begin
                    pace_next = time_sum(pace_next,
                                         (bytes * ppg_pkg::PACING_NUMERATOR) / bw);
                end
            end
            ppg_pkg::CMD_RTT_SAMPLE: begin
                pace_rtt_seen = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic ppg_pkg::t_ppg_in make_command(
        input logic [ppg_pkg::CMD_BITS-1:0]   command,
        input logic [ppg_pkg::TIME_BITS-1:0]  now,
        input logic [ppg_pkg::BYTES_BITS-1:0] bytes,
        input logic                           data,
        input logic                           blk,
        input logic [ppg_pkg::BW_BITS-1:0]    bw
    );
        ppg_pkg::t_ppg_in c;
        c.command = command;
        c.now_us = now;
        c.packet_bytes = bytes;
        c.has_data = data;
        c.underlying_blocked = blk;
        c.bandwidth_bps = bw;
        return c;
    endfunction

    // Offers one command in the sender's burst pattern and waits for its transfer.
    task automatic send_command(input ppg_pkg::t_ppg_in item);
        int gap;
        if (!sender_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        wait_expect_q.push_back(pace_step(item));
    endtask

    // Writes the granularity register once the block has drained.
    task automatic set_granularity(input logic [ppg_pkg::GRAN_BITS-1:0] value);
        i_in_valid <= 1'b0;
        while (wait_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GRAN_ADDR;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pace_gran = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Before any RTT sample every unblocked query passes and sends do not pace.
    task automatic test_before_rtt();
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd5000, 16'd1500, 1'b1, 1'b0,
                                  40'd1000000));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd5000, 16'd0, 1'b1, 1'b1,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, 16'd1500, 1'b1, 1'b0,
                                  40'd1000000));
        send_command(make_command(CMD_UNUSED, NOW_MAX, BYTES_MAX, 1'b1, 1'b1, BW_MAX));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, NOW_MAX, BYTES_MAX, 1'b0, 1'b0,
                                  BW_MAX));
    endtask

    // Pacing after the first RTT sample: delays, catch-up and ignored sends.
    task automatic test_directed_pacing();
        send_command(make_command(ppg_pkg::CMD_RTT_SAMPLE, NOW_MAX, BYTES_MAX, 1'b1, 1'b1,
                                  BW_MAX));
        // Uninitialized send time clamps back to zero.
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd700, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, 16'd1500, 1'b1, 1'b0,
                                  40'd1000000));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd100, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd4000, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd5000, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        // Far behind: the send time is pulled up to now minus the granularity.
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd100000, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, BYTES_MAX, 1'b0, 1'b0,
                                  40'd1));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, 16'd1500, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, 16'd0, 1'b1, 1'b0,
                                  BW_MAX));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, BYTES_MAX, 1'b1, 1'b0,
                                  40'd1));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd0, 16'd0, 1'b0, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd0, 16'd0, 1'b1, 1'b1,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd100000, 16'd0, 1'b1, 1'b0,
                                  40'd0));
    endtask

    // The receiver holds off for a long stretch while commands keep coming.
    task automatic test_output_hold_off();
        sender_steady = 1'b1;
        hold_requests++;
        send_command(make_command(ppg_pkg::CMD_RTT_SAMPLE, traffic_now, 16'd0, 1'b0, 1'b0,
                                  40'd0));
        for (int n = 0; n < 5; n++) begin
            traffic_now = traffic_now + 48'd1000;
            send_command(make_command(ppg_pkg::CMD_PACKET_SENT, traffic_now, 16'd1500, 1'b1,
                                      1'b0, 40'd100000));
            send_command(make_command(ppg_pkg::CMD_SEND_QUERY, traffic_now, 16'd0, 1'b1,
                                      1'b0, 40'd0));
        end
        sender_steady = 1'b0;
    endtask

    // Paced traffic with random content, mixed with malformed commands.
    task automatic test_random_traffic(input int count);
        ppg_pkg::t_ppg_in item;
        logic [63:0]      rnd_a;
        logic [63:0]      rnd_b;
        logic [15:0]      bytes;
        logic [39:0]      bw;
        int               pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            rnd_a = {$urandom, $urandom};
            rnd_b = {$urandom, $urandom};
            // Time moves forward, sometimes back, and often up to the paced send time.
            traffic_now = traffic_now + 48'($urandom_range(0, 2500));
            if ($urandom_range(0, 31) == 0) begin
                traffic_now = traffic_now - 48'($urandom_range(0, 50000));
            end
            if (pace_next > {16'd0, traffic_now} + 64'd100000 && $urandom_range(0, 1) == 1) begin
                traffic_now = pace_next[ppg_pkg::TIME_BITS-1:0] - 48'($urandom_range(0, 3000));
            end
            if ($urandom_range(0, 7) == 0) begin
                bytes = rnd_b[55:40];
            end else begin
                bytes = 16'($urandom_range(40, 1500));
            end
            case ($urandom_range(0, 9))
                0: bw = '0;
                1: bw = rnd_b[39:0];
                2: bw = 40'($urandom_range(1, 1000));
                default: bw = 40'($urandom_range(500000, 200000000));
            endcase
            if (pick < 45) begin
                item = make_command(ppg_pkg::CMD_SEND_QUERY, traffic_now, rnd_a[15:0],
                                    $urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0,
                                    rnd_a[63:24]);
            end else if (pick < 82) begin
                item = make_command(ppg_pkg::CMD_PACKET_SENT, rnd_a[47:0], bytes,
                                    $urandom_range(0, 7) != 0, rnd_a[48], bw);
            end else if (pick < 86) begin
                item = make_command(ppg_pkg::CMD_RTT_SAMPLE, rnd_a[47:0], rnd_b[15:0],
                                    rnd_a[50], rnd_a[51], rnd_b[55:16]);
            end else if (pick < 90) begin
                item = make_command(CMD_UNUSED, rnd_a[47:0], rnd_b[15:0], rnd_a[50],
                                    rnd_a[51], rnd_b[55:16]);
            end else begin
                item = make_command(2'($urandom_range(0, 3)), rnd_a[47:0], rnd_b[15:0],
                                    rnd_a[50], rnd_a[51], rnd_b[55:16]);
                if (item.command == ppg_pkg::CMD_SEND_QUERY) begin
                    traffic_now = item.now_us;
                end
            end
            send_command(item);
        end
    endtask

    // Saturation at the top of the time range; this leaves the send time at its
    // maximum for good, so it runs last.
    task automatic test_time_saturation();
        send_command(make_command(ppg_pkg::CMD_RTT_SAMPLE, 48'd0, 16'd0, 1'b0, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, NOW_MAX, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, NOW_MAX, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_PACKET_SENT, 48'd0, BYTES_MAX, 1'b1, 1'b0,
                                  40'd1));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd0, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, NOW_MAX, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd500, 16'd0, 1'b1, 1'b0,
                                  40'd0));
        send_command(make_command(ppg_pkg::CMD_SEND_QUERY, 48'd500, 16'd0, 1'b1, 1'b1,
                                  40'd0));
    endtask

    // Receiver stall pattern, with long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE: i_out_stall <= 1'b0;
                STALL_HALF: i_out_stall <= ($urandom_range(0, 1) == 1);
                STALL_MOST: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        ppg_pkg::t_ppg_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wait_expect_q.size() == 0) begin
                $display("%0t: unexpected result, got wait_us %h blocked %b", $time,
                         o_out_data.wait_us, o_out_data.blocked);
                errors++;
            end else begin
                want = wait_expect_q.pop_front();
                if (o_out_data.wait_us !== want.wait_us) begin
                    $display("%0t: wait_us expected %h, got %h", $time, want.wait_us,
                             o_out_data.wait_us);
                    errors++;
                end
                if (o_out_data.blocked !== want.blocked) begin
                    $display("%0t: blocked expected %b, got %b", $time, want.blocked,
                             o_out_data.blocked);
                    errors++;
                end
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_rtt();
        test_directed_pacing();
        set_granularity(20'd0);
        test_random_traffic(200);
        set_granularity(20'hFFFFF);
        test_random_traffic(150);
        set_granularity(20'd1);
        test_output_hold_off();
        test_random_traffic(150);
        set_granularity(20'd1000000);
        test_random_traffic(150);
        set_granularity(20'd250);
        test_random_traffic(200);
        test_time_saturation();

        // Drain the outstanding results.
        i_in_valid <= 1'b0;
        while (wait_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
